[rtl/core/rkxcc_pkg.sv]
`timescale 1ns / 1ps

package rkxcc_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORDS_W    = 6;
   localparam int BYTE_SUM_W = 20;
   localparam int KEY_LEN_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_A   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_B   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_C   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LEN = 2'd3;

   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 2'd3;
   localparam logic [BYTE_W-1:0] KEY_RESET [3] = '{8'h61, 8'h62, 8'h63};

   // Bit positions of the words in the mask.
   localparam int W_THE = 0;
   localparam int W_BE  = 1;
   localparam int W_TO  = 2;
   localparam int W_OF  = 3;
   localparam int W_AND = 4;
   localparam int W_IN  = 5;

   localparam logic [BYTE_W-1:0] CH_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_B = 8'h62;
   localparam logic [BYTE_W-1:0] CH_D = 8'h64;
   localparam logic [BYTE_W-1:0] CH_E = 8'h65;
   localparam logic [BYTE_W-1:0] CH_F = 8'h66;
   localparam logic [BYTE_W-1:0] CH_H = 8'h68;
   localparam logic [BYTE_W-1:0] CH_I = 8'h69;
   localparam logic [BYTE_W-1:0] CH_N = 8'h6e;
   localparam logic [BYTE_W-1:0] CH_O = 8'h6f;
   localparam logic [BYTE_W-1:0] CH_T = 8'h74;

   typedef struct packed {
      logic                  message_end;
      logic [BYTE_SUM_W-1:0] byte_sum;
      logic                  all_words_seen;
      logic [WORDS_W-1:0]    words_seen;
      logic [BYTE_W-1:0]     plain_byte;
   } result_type;

   function automatic logic [WORDS_W-1:0] detect_words(
      input logic [BYTE_W-1:0] older,
      input logic [BYTE_W-1:0] last,
      input logic [BYTE_W-1:0] cur
   );
      logic [WORDS_W-1:0] hit;
      hit        = '0;
      hit[W_THE] = (older == CH_T) && (last == CH_H) && (cur == CH_E);
      hit[W_BE]  = (last == CH_B) && (cur == CH_E);
      hit[W_TO]  = (last == CH_T) && (cur == CH_O);
      hit[W_OF]  = (last == CH_O) && (cur == CH_F);
      hit[W_AND] = (older == CH_A) && (last == CH_N) && (cur == CH_D);
      hit[W_IN]  = (last == CH_I) && (cur == CH_N);
      return hit;
   endfunction

endpackage

[rtl/core/rkxcc_csr.sv]
`timescale 1ns / 1ps

module rkxcc_csr #(
   parameter int MAX_KEY_BYTES = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rkxcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rkxcc_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [rkxcc_pkg::BYTE_W-1:0]      key_bytes [MAX_KEY_BYTES],
   output logic [rkxcc_pkg::KEY_LEN_W-1:0]   key_length
);

   logic [rkxcc_pkg::BYTE_W-1:0]    key_ff [MAX_KEY_BYTES];
   logic [rkxcc_pkg::KEY_LEN_W-1:0] key_len_ff;
   logic                            wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   // Key bytes beyond the supported count are never read, so they are not stored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            key_ff[i] <= rkxcc_pkg::KEY_RESET[i];
         end
         key_len_ff <= rkxcc_pkg::KEY_LEN_RESET;
      end else if (wr_en) begin
         case (csr_index)
            rkxcc_pkg::CSR_KEY_A: begin
               key_ff[0] <= csr_data;
            end
            rkxcc_pkg::CSR_KEY_B: begin
               if (MAX_KEY_BYTES > 1) begin
                  key_ff[MAX_KEY_BYTES > 1 ? 1 : 0] <= csr_data;
               end
            end
            rkxcc_pkg::CSR_KEY_C: begin
               if (MAX_KEY_BYTES > 2) begin
                  key_ff[MAX_KEY_BYTES > 2 ? 2 : 0] <= csr_data;
               end
            end
            rkxcc_pkg::CSR_KEY_LEN: begin
               key_len_ff <= csr_data[rkxcc_pkg::KEY_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign key_bytes  = key_ff;
   assign key_length = key_len_ff;

endmodule

[rtl/core/rkxcc_core.sv]
`timescale 1ns / 1ps

module rkxcc_core #(
   parameter int MAX_KEY_BYTES = 3,
   parameter int SUM_WIDTH     = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [rkxcc_pkg::BYTE_W-1:0]     cipher_byte,
   input  logic                             is_last,
   input  logic [rkxcc_pkg::BYTE_W-1:0]     key_bytes [MAX_KEY_BYTES],
   input  logic [rkxcc_pkg::KEY_LEN_W-1:0]  key_length,
   output rkxcc_pkg::result_type            result
);

   localparam int KW = rkxcc_pkg::KEY_LEN_W;
   localparam logic [KW-1:0] MAX_LEN = KW'(MAX_KEY_BYTES);

   logic [KW-1:0]                     pos_ff, pos_in;
   logic [2*rkxcc_pkg::BYTE_W-1:0]    prev_ff, prev_in;
   logic [rkxcc_pkg::WORDS_W-1:0]     mask_ff, mask_in;
   logic [SUM_WIDTH-1:0]              sum_ff, sum_in;

   logic [KW-1:0]                     eff_len;
   logic [KW-1:0]                     pos_cur;
   logic [KW-1:0]                     pos_inc;
   logic [rkxcc_pkg::BYTE_W-1:0]      key_cur;
   logic [rkxcc_pkg::BYTE_W-1:0]      plain;
   logic [SUM_WIDTH:0]                sum_wide;
   logic [SUM_WIDTH-1:0]              sum_sat;
   logic [rkxcc_pkg::WORDS_W-1:0]     mask_new;

   always_comb begin
      if (key_length == '0) begin
         eff_len = KW'(1);
      end else if (key_length > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = key_length;
      end

      // A position left out of range by a length change mid-message restarts at zero.
      pos_cur = (pos_ff >= eff_len) ? '0 : pos_ff;
      pos_inc = pos_cur + KW'(1);

      key_cur = key_bytes[0];
      for (int i = 1; i < MAX_KEY_BYTES; i++) begin
         if (pos_cur == KW'(i)) begin
            key_cur = key_bytes[i];
         end
      end

      plain    = cipher_byte ^ key_cur;
      mask_new = mask_ff | rkxcc_pkg::detect_words(prev_ff[15:8], prev_ff[7:0], plain);
      sum_wide = {1'b0, sum_ff} + {{(SUM_WIDTH + 1 - rkxcc_pkg::BYTE_W){1'b0}}, plain};
      sum_sat  = sum_wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_wide[SUM_WIDTH-1:0];

      pos_in  = pos_ff;
      prev_in = prev_ff;
      mask_in = mask_ff;
      sum_in  = sum_ff;
      if (accept) begin
         if (is_last) begin
            pos_in  = '0;
            prev_in = '0;
            mask_in = '0;
            sum_in  = '0;
         end else begin
            pos_in  = (pos_inc >= eff_len) ? '0 : pos_inc;
            prev_in = {prev_ff[7:0], plain};
            mask_in = mask_new;
            sum_in  = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         prev_ff <= '0;
         mask_ff <= '0;
         sum_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         mask_ff <= mask_in;
         sum_ff  <= sum_in;
      end
   end

   generate
      if (SUM_WIDTH >= rkxcc_pkg::BYTE_SUM_W) begin : g_sum_trunc
         assign result.byte_sum = sum_sat[rkxcc_pkg::BYTE_SUM_W-1:0];
      end else begin : g_sum_ext
         assign result.byte_sum =
            {{(rkxcc_pkg::BYTE_SUM_W - SUM_WIDTH){1'b0}}, sum_sat};
      end
   endgenerate

   assign result.plain_byte     = plain;
   assign result.words_seen     = mask_new;
   assign result.all_words_seen = &mask_new;
   assign result.message_end    = is_last;

endmodule

[rtl/core/rkxcc_out_buf.sv]
`timescale 1ns / 1ps

module rkxcc_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rkxcc_pkg::result_type  push_data,
   output logic                   push_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rkxcc_pkg::result_type  out_data
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   rkxcc_pkg::result_type out_ff, out_in;
   rkxcc_pkg::result_type skid_ff, skid_in;
   logic                  pop;

   assign pop        = out_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;

   // The skid slot holds a result accepted while the output slot is stalled.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            out_valid_in = push;
            out_in       = push_data;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end else begin
            out_valid_in = 1'b1;
            out_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

[rtl/core/repeating_key_xor_crib_check.sv]
`timescale 1ns / 1ps
// Results are registered in the output slot, or the skid slot while the output stalls.
// Throughput: one byte per cycle unless the skid slot is full; the per-byte work sits
// between the state registers and a two-slot output register (output, skid).
// Reset is synchronous and active high: it clears the message state and the output
// slots and loads the key bytes 0x61, 0x62, 0x63 with a key length of three.

module repeating_key_xor_crib_check #(
   parameter int MAX_KEY_BYTES = 3,
   parameter int SUM_WIDTH     = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rkxcc_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] cipher_byte
   input  logic                              req_tlast,  // is_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] plain_byte, [13:8] words_seen, [14] all_words_seen, [34:15] byte_sum,
   // [39:35] zero
   output logic [rkxcc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,  // message_end
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rkxcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rkxcc_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [rkxcc_pkg::BYTE_W-1:0]    key_bytes [MAX_KEY_BYTES];
   logic [rkxcc_pkg::KEY_LEN_W-1:0] key_length;
   logic                            accept;
   rkxcc_pkg::result_type           new_result;
   rkxcc_pkg::result_type           rsp_result;

   assign accept = req_tvalid && req_tready;

   rkxcc_csr #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .key_bytes  (key_bytes),
      .key_length (key_length)
   );

   rkxcc_core #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .SUM_WIDTH     (SUM_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cipher_byte (req_tdata[rkxcc_pkg::BYTE_W-1:0]),
      .is_last     (req_tlast),
      .key_bytes   (key_bytes),
      .key_length  (key_length),
      .result      (new_result)
   );

   rkxcc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (new_result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_result)
   );

   assign rsp_tdata = {5'b0, rsp_result.byte_sum, rsp_result.all_words_seen,
                       rsp_result.words_seen, rsp_result.plain_byte};
   assign rsp_tlast = rsp_result.message_end;

   // A full skid slot can only exist behind a valid output slot.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("skid slot full while output slot empty");

   // A transaction taken while the output stalls must fill the skid slot.
   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tvalid && !rsp_tready) |=> !req_tready)
      else $error("result accepted during stall was not held in skid slot");

   // The all-words flag must agree with the mask in the same result.
   a_all_words_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14] == (&rsp_tdata[13:8])))
      else $error("all_words_seen disagrees with words_seen");

endmodule

[sim/rkxcc_plaintext_checker.sv]
`timescale 1ns / 1ps

module rkxcc_plaintext_checker
   import rkxcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // [7:0] cipher_byte
   input  logic                   req_tlast,  // is_last
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] plain_byte, [13:8] words_seen, [14] all_words_seen, [34:15] byte_sum,
   // [39:35] zero
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tlast,  // message_end
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     pending,
   output logic [BYTE_W-1:0]      next_key
);

   logic [BYTE_W-1:0]     key_bytes [3];
   logic [KEY_LEN_W-1:0]  key_len;
   logic [KEY_LEN_W-1:0]  key_pos;
   logic [KEY_LEN_W-1:0]  eff_len;
   logic [BYTE_W-1:0]     prev_char;
   logic [BYTE_W-1:0]     older_char;
   logic [WORDS_W-1:0]    seen_mask;
   logic [BYTE_SUM_W-1:0] plain_sum;
   result_type            expected_plain [$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // A length of zero behaves as a single key byte.
   assign eff_len  = (key_len == '0) ? 2'd1 : key_len;
   assign next_key = (key_pos >= eff_len) ? key_bytes[0] : key_bytes[key_pos];

   function automatic logic [WORDS_W-1:0] crib_hits(
      input logic [BYTE_W-1:0] older,
      input logic [BYTE_W-1:0] recent,
      input logic [BYTE_W-1:0] cur
   );
      logic [3*BYTE_W-1:0] tri_chars;
      logic [WORDS_W-1:0]  hits;
      tri_chars  = {older, recent, cur};
      hits       = '0;
      hits[W_THE] = (tri_chars == {CH_T, CH_H, CH_E});
      hits[W_AND] = (tri_chars == {CH_A, CH_N, CH_D});
      hits[W_BE]  = (tri_chars[2*BYTE_W-1:0] == {CH_B, CH_E});
      hits[W_TO]  = (tri_chars[2*BYTE_W-1:0] == {CH_T, CH_O});
      hits[W_OF]  = (tri_chars[2*BYTE_W-1:0] == {CH_O, CH_F});
      hits[W_IN]  = (tri_chars[2*BYTE_W-1:0] == {CH_I, CH_N});
      return hits;
   endfunction

   task automatic clear_message();
      key_pos    = '0;
      prev_char  = '0;
      older_char = '0;
      seen_mask  = '0;
      plain_sum  = '0;
   endtask

   task automatic decipher_byte(input logic [BYTE_W-1:0] cipher, input logic last_flag);
      result_type            r;
      logic [KEY_LEN_W-1:0]  pos;
      logic [BYTE_W-1:0]     plain;
      logic [BYTE_SUM_W:0]   wide_sum;
      // A position left beyond a shortened key falls back to the first key byte.
      pos   = (key_pos >= eff_len) ? 2'd0 : key_pos;
      plain = cipher ^ key_bytes[pos];
      key_pos = (int'(pos) + 1 >= int'(eff_len)) ? 2'd0 : pos + 2'd1;
      seen_mask  = seen_mask | crib_hits(older_char, prev_char, plain);
      older_char = prev_char;
      prev_char  = plain;
      wide_sum   = {1'b0, plain_sum} + plain;
      plain_sum  = wide_sum[BYTE_SUM_W] ? '1 : wide_sum[BYTE_SUM_W-1:0];
      r.plain_byte     = plain;
      r.words_seen     = seen_mask;
      r.all_words_seen = &seen_mask;
      r.byte_sum       = plain_sum;
      r.message_end    = last_flag;
      expected_plain = {expected_plain, r};
      if (last_flag) clear_message();
   endtask

   task automatic note_mismatch(input string what, input logic [39:0] got,
                                input logic [39:0] want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         key_bytes = KEY_RESET;
         key_len   = KEY_LEN_RESET;
         clear_message();
         expected_plain.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_A:   key_bytes[0] = csr_data;
               CSR_KEY_B:   key_bytes[1] = csr_data;
               CSR_KEY_C:   key_bytes[2] = csr_data;
               CSR_KEY_LEN: key_len = csr_data[KEY_LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) decipher_byte(req_tdata[BYTE_W-1:0], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_plain.size() == 0) begin
               note_mismatch("unexpected result transaction", rsp_tdata, '0);
            end else begin
               want = expected_plain.pop_front();
               if (rsp_tdata[7:0] !== want.plain_byte)
                  note_mismatch("plain_byte", rsp_tdata[7:0], want.plain_byte);
               if (rsp_tdata[13:8] !== want.words_seen)
                  note_mismatch("words_seen", rsp_tdata[13:8], want.words_seen);
               if (rsp_tdata[14] !== want.all_words_seen)
                  note_mismatch("all_words_seen", rsp_tdata[14], want.all_words_seen);
               if (rsp_tdata[34:15] !== want.byte_sum)
                  note_mismatch("byte_sum", rsp_tdata[34:15], want.byte_sum);
               if (rsp_tdata[39:35] !== '0)
                  note_mismatch("tdata padding", rsp_tdata[39:35], '0);
               if (rsp_tlast !== want.message_end)
                  note_mismatch("message_end", rsp_tlast, want.message_end);
            end
         end
      end
      pending = expected_plain.size();
   end

endmodule

[sim/repeating_key_xor_crib_check_tb.sv]
`timescale 1ns / 1ps

module repeating_key_xor_crib_check_tb;
   import rkxcc_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // [7:0] cipher_byte
   logic                   req_tlast = 1'b0; // is_last
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] plain_byte, [13:8] words_seen, [14] all_words_seen, [34:15] byte_sum,
   // [39:35] zero
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;        // message_end
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int                     mismatches;
   int                     pending;
   logic [BYTE_W-1:0]      next_key;

   logic                   sender_idles = 1'b0;
   logic                   receiver_stalls = 1'b0;
   int                     idle_pct = 67;
   int                     hold_asked = 0;
   int                     hold_seen = 0;
   int                     hold_left = 0;

   logic [BYTE_W-1:0]      text_q [$];
   string                  word_list [6] = '{"the", "be", "to", "of", "and", "in"};
   string                  letters = "tehbonadifTE ";

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   repeating_key_xor_crib_check u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rkxcc_plaintext_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .next_key   (next_key)
   );

   // Receiver: a requested hold keeps tready low for a long stretch.
   always @(negedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = 64;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= receiver_stalls ? ($urandom_range(99) >= idle_pct) : 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   // With as_plain set, the value is the wanted plaintext and is keyed here.
   task automatic offer_byte(input logic [BYTE_W-1:0] value, input logic as_plain,
                             input logic last_flag);
      while (sender_idles && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= as_plain ? (value ^ next_key) : value;
      req_tlast  <= last_flag;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int          phase;
      int          n;
      int          k;
      string       crib;
      logic [BYTE_W-1:0] ch;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Byte extremes under the reset key.
      offer_byte(8'h00, 1'b0, 1'b0);
      offer_byte(8'hff, 1'b0, 1'b0);
      offer_byte(8'h80, 1'b0, 1'b0);
      offer_byte(8'h7f, 1'b0, 1'b0);
      offer_byte(8'h61, 1'b0, 1'b1);

      // All six words, preceded by an upper-case one that must not count.
      settle_block();
      csr_write(CSR_KEY_A, 8'h00);
      csr_write(CSR_KEY_B, 8'hff);
      csr_write(CSR_KEY_C, 8'h80);
      csr_write(CSR_KEY_LEN, 8'd1);
      crib = "THEtheandinoftobe";
      for (n = 0; n < crib.len(); n++)
         offer_byte(crib[n], 1'b1, n == crib.len() - 1);

      // Messages are left open across phases so that a shorter key length
      // can meet a key position beyond it.
      for (phase = 0; phase < 8; phase++) begin
         settle_block();
         sender_idles    = (phase % 4 == 1) || (phase % 4 == 3);
         receiver_stalls = (phase % 4 == 2) || (phase % 4 == 3);
         idle_pct        = (phase % 4 == 3) ? 25 : 67;
         csr_write(CSR_KEY_A, (phase == 0) ? 8'h00 : (phase == 1) ? 8'hff : 8'($urandom));
         csr_write(CSR_KEY_B, (phase == 0) ? 8'hff : (phase == 1) ? 8'h00 : 8'($urandom));
         csr_write(CSR_KEY_C, (phase == 0) ? 8'h00 : (phase == 1) ? 8'hff : 8'($urandom));
         csr_write(CSR_KEY_LEN, 8'(phase % 4));
         if (phase == 0) hold_asked++;
         for (n = 0; n < 80; n++) begin
            if (phase == 4 && n == 50) settle_block();
            if ($urandom_range(99) < 25) begin
               offer_byte(8'($urandom), 1'b0, $urandom_range(39) == 0);
            end else begin
               if (text_q.size() == 0) begin
                  k = $urandom_range(9);
                  if (k < 6) begin
                     for (int i = 0; i < word_list[k].len(); i++)
                        text_q = {text_q, word_list[k][i]};
                  end else begin
                     text_q = {text_q, letters[$urandom_range(letters.len() - 1)]};
                  end
               end
               ch = text_q.pop_front();
               offer_byte(ch, 1'b1, $urandom_range(29) == 0);
            end
         end
      end

      // One long message of 0xff plaintext drives the running sum up.
      settle_block();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      csr_write(CSR_KEY_A, 8'($urandom));
      csr_write(CSR_KEY_LEN, 8'd2);
      offer_byte(8'h00, 1'b0, 1'b1);
      for (n = 0; n < 180; n++) offer_byte(8'hff, 1'b1, 1'b0);
      offer_byte(8'h01, 1'b1, 1'b0);
      offer_byte(8'($urandom), 1'b0, 1'b1);
      offer_byte(8'h05, 1'b1, 1'b1);

      settle_block();
      repeat (4) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("** repeating_key_xor_crib_check: PASSED **");
      end else begin
         $display("** repeating_key_xor_crib_check: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("** repeating_key_xor_crib_check: FAILED **");
      $finish;
   end

endmodule
